FILE: design/lsnh_pkg.sv
// ----------------------------------------------------------------------------
// lsnh_pkg
// Types and constants shared by the link-state next-hop solver and its RAM.
// ----------------------------------------------------------------------------
package lsnh_pkg;

    localparam int NODES      = 32;
    localparam int NODE_W     = 5;
    localparam int LINK_DEPTH = NODES * NODES;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);
    localparam int COST_W     = 16;
    localparam int LINK_W     = COST_W + 1;
    localparam int EMIT_COUNT = (NODES < 32) ? NODES : 32;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        ST_UNSEEN  = 2'd0,
        ST_WAIT    = 2'd1,
        ST_SETTLED = 2'd2
    } t_node_st;

    typedef struct packed {
        logic [1:0]        op;
        logic [4:0]        src_node;
        logic [4:0]        dst_node;
        logic [15:0]       link_metric;
    } t_in_item;

    typedef struct packed {
        logic [4:0]        dest_node;
        logic [4:0]        next_hop;
        logic [15:0]       path_cost;
        logic              reachable;
        logic              last;
    } t_out_item;

endpackage

FILE: design/lsnh_ram.sv
// ----------------------------------------------------------------------------
// lsnh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lsnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/link_state_next_hop_solver.sv
// ----------------------------------------------------------------------------
// link_state_next_hop_solver
// Link table with a sequential Dijkstra search that emits a next-hop table.
// ----------------------------------------------------------------------------
//  Channel  Signals                              Direction
//  in       i_in_valid, o_in_stall, i_in_data    link ops and compute requests
//  out      o_out_valid, i_out_stall, o_out_data routing entries, 32 beats
//  cfg      i_cfg_we, i_cfg_wdata                self node register
//
// After reset the link RAM is cleared; input is stalled then.
// A link write or remove is written to the RAM in the cycle it is accepted.
// A compute runs a setup step, settles the root, then repeats rounds (minimum
// search, batch snapshot, descending scan that settles each batch node) until a
// search finds nothing waiting; then the 32 result entries are emitted.
// Output stalls hold the result register and pause the table walk.
module link_state_next_hop_solver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lsnh_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lsnh_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata
);
    import lsnh_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_INIT, S_MIN, S_BATCH, S_SEL, S_SETTLE, S_EMIT
    } t_state;

    t_state              r_state;
    logic [LINK_AW-1:0]  r_caddr;
    logic [NODE_W-1:0]   r_self;
    t_node_st            r_status [NODES];
    logic [COST_W-1:0]   r_best [NODES];
    logic [NODE_W-1:0]   r_fh [NODES];
    logic [NODES-1:0]    r_batch;
    logic [NODE_W-1:0]   r_v;
    logic [NODE_W-1:0]   r_d;
    logic [NODE_W-1:0]   r_dp;
    logic                r_issuing;
    logic                r_pv;
    logic                r_root;
    logic [COST_W-1:0]   r_vcost;
    logic [NODE_W-1:0]   r_vfh;
    logic                r_any;
    logic [COST_W-1:0]   r_lo;
    logic                r_ovalid;
    t_out_item           r_odata;

    logic                ram_we;
    logic [LINK_AW-1:0]  ram_waddr;
    logic [LINK_W-1:0]   ram_wdata;
    logic [LINK_AW-1:0]  ram_raddr;
    logic [LINK_W-1:0]   ram_rdata;
    logic                in_acc;
    logic [COST_W:0]     sum_raw;
    logic [COST_W-1:0]   sum_sat;
    logic [NODE_W-1:0]   hop;
    logic                out_free;

    lsnh_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign sum_raw    = {1'b0, r_vcost} + {1'b0, ram_rdata[COST_W-1:0]};
    assign sum_sat    = sum_raw[COST_W] ? COST_MAX : sum_raw[COST_W-1:0];
    assign hop        = r_root ? r_dp : r_vfh;
    assign ram_raddr  = {r_v, r_d};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {i_in_data.src_node, i_in_data.dst_node};
        ram_wdata = {(i_in_data.op == OP_WRITE), i_in_data.link_metric};
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_caddr;
            ram_wdata = '0;
        end else if (in_acc && (i_in_data.op == OP_WRITE || i_in_data.op == OP_REMOVE)) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_caddr   <= '0;
            r_self    <= '0;
            r_issuing <= 1'b0;
            r_pv      <= 1'b0;
            r_ovalid  <= 1'b0;
            r_batch   <= '0;
            for (int i = 0; i < NODES; i++) begin
                r_status[i] <= ST_UNSEEN;
            end
        end else begin
            if (i_cfg_we) begin
                r_self <= i_cfg_wdata;
            end
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_caddr <= r_caddr + LINK_AW'(1);
                    if (r_caddr == LINK_AW'(LINK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && i_in_data.op == OP_COMPUTE) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    for (int i = 0; i < NODES; i++) begin
                        r_status[i] <= ST_UNSEEN;
                    end
                    if ({1'b0, r_self} >= (NODE_W + 1)'(NODES)) begin
                        r_v     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        // The root is settled like any node, but its
                        // neighbors take themselves as first hop.
                        r_status[r_self] <= ST_SETTLED;
                        r_best[r_self]   <= '0;
                        r_fh[r_self]     <= r_self;
                        r_v       <= r_self;
                        r_vcost   <= '0;
                        r_root    <= 1'b1;
                        r_d       <= '0;
                        r_issuing <= 1'b1;
                        r_state   <= S_SETTLE;
                    end
                end
                S_MIN: begin
                    if (r_status[r_v] == ST_WAIT) begin
                        r_any <= 1'b1;
                        if (r_best[r_v] < r_lo) begin
                            r_lo <= r_best[r_v];
                        end
                    end
                    r_v <= r_v + NODE_W'(1);
                    if (r_v == NODE_W'(NODES - 1)) begin
                        r_state <= S_BATCH;
                    end
                end
                S_BATCH: begin
                    if (!r_any) begin
                        r_v     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        for (int i = 0; i < NODES; i++) begin
                            r_batch[i] <= (r_status[i] == ST_WAIT) && (r_best[i] == r_lo);
                        end
                        r_v     <= NODE_W'(NODES - 1);
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_batch[r_v]) begin
                        r_batch[r_v]  <= 1'b0;
                        r_status[r_v] <= ST_SETTLED;
                        r_vcost   <= r_best[r_v];
                        r_vfh     <= r_fh[r_v];
                        r_root    <= 1'b0;
                        r_d       <= '0;
                        r_issuing <= 1'b1;
                        r_state   <= S_SETTLE;
                    end else if (r_v == '0) begin
                        r_any   <= 1'b0;
                        r_lo    <= COST_MAX;
                        r_state <= S_MIN;
                    end else begin
                        r_v <= r_v - NODE_W'(1);
                    end
                end
                S_SETTLE: begin
                    // One link read is issued per cycle; its data is used
                    // on the following cycle for the node held in r_dp.
                    r_pv <= r_issuing;
                    r_dp <= r_d;
                    if (r_issuing) begin
                        r_d <= r_d + NODE_W'(1);
                        if (r_d == NODE_W'(NODES - 1)) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    if (r_pv && ram_rdata[COST_W] && r_status[r_dp] != ST_SETTLED) begin
                        if (r_status[r_dp] == ST_UNSEEN) begin
                            r_status[r_dp] <= ST_WAIT;
                            r_best[r_dp]   <= sum_sat;
                            r_fh[r_dp]     <= hop;
                        end else if (r_best[r_dp] > sum_sat) begin
                            r_best[r_dp] <= sum_sat;
                            r_fh[r_dp]   <= hop;
                        end
                    end
                    if (r_pv && !r_issuing) begin
                        r_pv <= 1'b0;
                        if (r_root || r_v == '0) begin
                            r_v     <= '0;
                            r_any   <= 1'b0;
                            r_lo    <= COST_MAX;
                            r_state <= S_MIN;
                        end else begin
                            r_v     <= r_v - NODE_W'(1);
                            r_state <= S_SEL;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid            <= 1'b1;
                        r_odata.dest_node   <= r_v;
                        r_odata.last        <= (r_v == NODE_W'(EMIT_COUNT - 1));
                        if (r_v == r_self) begin
                            r_odata.next_hop  <= r_v;
                            r_odata.path_cost <= '0;
                            r_odata.reachable <= 1'b0;
                        end else if (r_status[r_v] == ST_SETTLED) begin
                            r_odata.next_hop  <= r_fh[r_v];
                            r_odata.path_cost <= r_best[r_v];
                            r_odata.reachable <= 1'b1;
                        end else begin
                            r_odata.next_hop  <= '0;
                            r_odata.path_cost <= COST_MAX;
                            r_odata.reachable <= 1'b0;
                        end
                        r_v <= r_v + NODE_W'(1);
                        if (r_v == NODE_W'(EMIT_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    a_last_is_final_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last) |-> o_out_data.dest_node == NODE_W'(EMIT_COUNT - 1))
        else $error("last beat on a node other than the final one");

    a_self_unreachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.reachable) |-> o_out_data.dest_node != r_self)
        else $error("self entry marked reachable");

    a_unreach_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.reachable && o_out_data.dest_node != r_self)
        |-> o_out_data.path_cost == COST_MAX)
        else $error("unreachable entry without saturated cost");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input accepted during link table clear");

endmodule
